// ----- rtl/gles_pkg.sv -----
package gles_pkg;

  // Search limits
  localparam int unsigned LINE_MAX      = 4096;
  localparam int unsigned SEARCH_RADIUS = 64;
  localparam int unsigned MIN_SPAN      = 40;

  // Field widths
  localparam int unsigned POS_W     = 12;
  localparam int unsigned SPAN_W    = 13;
  localparam int unsigned GRAD_W    = 10;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned HITS_W    = 13;
  localparam int unsigned SCORE_W   = 23;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Result queue depth
  localparam int unsigned RES_DEPTH = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CLAMP  = 1'b1;

  localparam logic [CFG_W-1:0] HIT_THRESHOLD_RST = 10'd64;
  localparam logic [CFG_W-1:0] SAMPLE_CLAMP_RST  = 10'd320;

  // Item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Record of one item leaving the accumulate stage
  typedef struct packed {
    logic              hdr;
    logic              close;
    logic              jend;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos_delta;
    logic [SPAN_W-1:0] span;
    logic [SUM_W-1:0]  sum;
    logic [HITS_W-1:0] hits;
  } line_t;

  // Record of one item leaving the score pipeline
  typedef struct packed {
    logic                      hdr;
    logic                      close;
    logic                      jend;
    logic [POS_W-1:0]          pos;
    logic                      qual;
    logic signed [SCORE_W-1:0] score;
  } scored_t;

  typedef struct packed {
    logic                      found;
    logic [POS_W-1:0]          pos;
    logic signed [SCORE_W-1:0] score;
  } result_t;

endpackage

// ----- rtl/gles_score.sv -----
module gles_score (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              line_v,
  input  gles_pkg::line_t   line_in,
  output logic              scored_v,
  output gles_pkg::scored_t scored,
  output logic [1:0]        pend_jend
);

  typedef struct packed {
    logic                          hdr;
    logic                          close;
    logic                          jend;
    logic [gles_pkg::POS_W-1:0]    pos;
    logic                          qual;
    logic [gles_pkg::SCORE_W-1:0]  gain;
    logic [24:0]                   pen;
  } mid_t;

  localparam logic signed [27:0] SAT_HI = 28'sd4194303;
  localparam logic signed [27:0] SAT_LO = -28'sd4194304;

  logic              p1_v_r;
  gles_pkg::line_t   p1_r;
  logic              p2_v_r;
  mid_t              p2_r;
  mid_t              p2_nxt;
  logic              p3_v_r;
  gles_pkg::scored_t p3_r;
  gles_pkg::scored_t p3_nxt;

  logic [17:0]       hits20;
  logic [17:0]       span11;
  logic [25:0]       pen3;
  logic signed [27:0] raw;

  // Stage 1: qualify, gain and distance penalty product
  always_comb begin
    hits20 = ({5'b0, p1_r.hits} << 4) + ({5'b0, p1_r.hits} << 2);
    span11 = ({5'b0, p1_r.span} << 3) + ({5'b0, p1_r.span} << 1) + {5'b0, p1_r.span};
    p2_nxt.hdr   = p1_r.hdr;
    p2_nxt.close = p1_r.close;
    p2_nxt.jend  = p1_r.jend;
    p2_nxt.pos   = p1_r.pos;
    p2_nxt.qual  = p1_r.close
                && (p1_r.span >= gles_pkg::SPAN_W'(gles_pkg::MIN_SPAN))
                && (p1_r.pos_delta <= gles_pkg::POS_W'(gles_pkg::SEARCH_RADIUS))
                && (hits20 >= span11);
    p2_nxt.gain  = {1'b0, p1_r.sum, 1'b0} + {2'b0, p1_r.hits, 8'b0};
    p2_nxt.pen   = {12'b0, p1_r.span} * {13'b0, p1_r.pos_delta};
  end

  // Stage 2: subtract 3x penalty and saturate to the score range
  always_comb begin
    pen3 = {p2_r.pen, 1'b0} + {1'b0, p2_r.pen};
    raw  = $signed({5'b0, p2_r.gain}) - $signed({2'b0, pen3});
    p3_nxt.hdr   = p2_r.hdr;
    p3_nxt.close = p2_r.close;
    p3_nxt.jend  = p2_r.jend;
    p3_nxt.pos   = p2_r.pos;
    p3_nxt.qual  = p2_r.qual;
    if (raw > SAT_HI) begin
      p3_nxt.score = SAT_HI[gles_pkg::SCORE_W-1:0];
    end else if (raw < SAT_LO) begin
      p3_nxt.score = SAT_LO[gles_pkg::SCORE_W-1:0];
    end else begin
      p3_nxt.score = raw[gles_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= line_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= line_in;
    p2_r <= p2_nxt;
    p3_r <= p3_nxt;
  end

  assign scored_v  = p3_v_r;
  assign scored    = p3_r;
  assign pend_jend = 2'(p1_v_r && p1_r.jend) + 2'(p2_v_r && p2_r.jend)
                   + 2'(p3_v_r && p3_r.jend);

endmodule

// ----- rtl/gles_res_fifo.sv -----
module gles_res_fifo #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = gles_pkg::RES_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ----- rtl/gradient_line_edge_search.sv -----
// Picks the best-scoring candidate edge line from a stream of gradient
// samples. Send a header item (tuser = 0) with the expected position and line
// length, then the samples of each line (tuser = 1), line_last on the last
// sample of a line and tlast on the last sample of the job. One item is taken
// every cycle while in_tready is high: sample accumulation happens as the item
// is accepted, and the line score runs through a three-stage pipeline (qualify
// and multiply, saturate, best compare). The job's single result item goes
// into an 8-entry queue after its last sample's best compare; in_tready drops
// only when queued results plus job ends still in the pipeline fill it, which
// takes a stalled output side. Configuration writes are taken at once.
module gradient_line_edge_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gles_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gles_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // expected_pos[11:0], line_span[24:12], grad_value[34:25], line_pos[46:35],
  // line_last[47]
  input  logic [gles_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind[0]
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // edge_pos[11:0], edge_score[34:12], zero[39:35]
  output logic [gles_pkg::OUT_DATA_W-1:0]     out_tdata,
  // found[0]
  output logic                                out_tuser
);

  localparam int unsigned CNT_W = $clog2(gles_pkg::RES_DEPTH + 1);
  localparam int unsigned RES_W = $bits(gles_pkg::result_t);

  logic [gles_pkg::CFG_W-1:0]   hit_thr_r;
  logic [gles_pkg::CFG_W-1:0]   clamp_r;

  logic [gles_pkg::SUM_W-1:0]   line_sum_r;
  logic [gles_pkg::SUM_W-1:0]   line_sum_nxt;
  logic [gles_pkg::HITS_W-1:0]  line_hits_r;
  logic [gles_pkg::HITS_W-1:0]  line_hits_nxt;
  logic [gles_pkg::POS_W-1:0]   job_expected_r;
  logic [gles_pkg::SPAN_W-1:0]  job_span_r;

  logic                         have_best_r;
  logic [gles_pkg::POS_W-1:0]   best_pos_r;
  logic signed [gles_pkg::SCORE_W-1:0] best_score_r;

  logic                         acc;
  logic                         is_sample;
  logic [gles_pkg::POS_W-1:0]   f_expected;
  logic [gles_pkg::SPAN_W-1:0]  f_span;
  logic [gles_pkg::GRAD_W-1:0]  f_grad;
  logic [gles_pkg::POS_W-1:0]   f_pos;
  logic                         f_line_last;

  logic [gles_pkg::GRAD_W-1:0]  clamped;
  logic [gles_pkg::SUM_W:0]     sum_add;
  logic [gles_pkg::SUM_W-1:0]   sum_upd;
  logic [gles_pkg::HITS_W-1:0]  hits_upd;
  gles_pkg::line_t              line_rec;

  logic                         scored_v;
  gles_pkg::scored_t            scored;
  logic [1:0]                   pend_jend;

  logic                         take;
  logic                         cand_have;
  logic [gles_pkg::POS_W-1:0]   cand_pos;
  logic signed [gles_pkg::SCORE_W-1:0] cand_score;
  logic                         push;
  gles_pkg::result_t            push_res;
  logic [RES_W-1:0]             head_bits;
  gles_pkg::result_t            head_res;
  logic [CNT_W-1:0]             q_count;

  assign f_expected  = in_tdata[11:0];
  assign f_span      = in_tdata[24:12];
  assign f_grad      = in_tdata[34:25];
  assign f_pos       = in_tdata[46:35];
  assign f_line_last = in_tdata[47];

  assign in_tready = (4'(q_count) + 4'(pend_jend)) < 4'(gles_pkg::RES_DEPTH);
  assign acc       = in_tvalid && in_tready;
  assign is_sample = (in_tuser == gles_pkg::KIND_SAMPLE);

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_thr_r <= gles_pkg::HIT_THRESHOLD_RST;
      clamp_r   <= gles_pkg::SAMPLE_CLAMP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        gles_pkg::REG_HIT_THRESHOLD: hit_thr_r <= cfg_wdata;
        gles_pkg::REG_SAMPLE_CLAMP:  clamp_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accumulate the current line as the item is accepted
  always_comb begin
    clamped  = (f_grad < clamp_r) ? f_grad : clamp_r;
    sum_add  = {1'b0, line_sum_r} + (gles_pkg::SUM_W+1)'(clamped);
    sum_upd  = sum_add[gles_pkg::SUM_W] ? '1 : sum_add[gles_pkg::SUM_W-1:0];
    hits_upd = line_hits_r;
    if ((f_grad >= hit_thr_r) && (line_hits_r != '1)) begin
      hits_upd = line_hits_r + gles_pkg::HITS_W'(1);
    end

    line_rec.hdr       = !is_sample;
    line_rec.close     = is_sample && (f_line_last || in_tlast);
    line_rec.jend      = is_sample && in_tlast;
    line_rec.pos       = f_pos;
    line_rec.pos_delta = (f_pos >= job_expected_r) ? f_pos - job_expected_r
                                                   : job_expected_r - f_pos;
    line_rec.span      = job_span_r;
    line_rec.sum       = sum_upd;
    line_rec.hits      = hits_upd;

    if (!is_sample || line_rec.close) begin
      line_sum_nxt  = '0;
      line_hits_nxt = '0;
    end else begin
      line_sum_nxt  = sum_upd;
      line_hits_nxt = hits_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sum_r     <= '0;
      line_hits_r    <= '0;
      job_expected_r <= '0;
      job_span_r     <= '0;
    end else if (acc) begin
      line_sum_r  <= line_sum_nxt;
      line_hits_r <= line_hits_nxt;
      if (!is_sample) begin
        job_expected_r <= f_expected;
        job_span_r     <= ({1'b0, f_span} > 14'(gles_pkg::LINE_MAX))
                          ? gles_pkg::SPAN_W'(gles_pkg::LINE_MAX) : f_span;
      end
    end
  end

  gles_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .line_v    (acc),
    .line_in   (line_rec),
    .scored_v  (scored_v),
    .scored    (scored),
    .pend_jend (pend_jend)
  );

  // Best line tracking; earliest line keeps a tie
  always_comb begin
    take       = scored.close && scored.qual
              && (!have_best_r || (scored.score > best_score_r));
    cand_have  = have_best_r || take;
    cand_pos   = take ? scored.pos : best_pos_r;
    cand_score = take ? scored.score : best_score_r;

    push           = scored_v && scored.jend;
    push_res.found = cand_have;
    push_res.pos   = cand_have ? cand_pos : '0;
    push_res.score = cand_have ? cand_score : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r  <= 1'b0;
      best_pos_r   <= '0;
      best_score_r <= '0;
    end else if (scored_v) begin
      if (scored.hdr || scored.jend) begin
        have_best_r  <= 1'b0;
        best_pos_r   <= '0;
        best_score_r <= '0;
      end else begin
        have_best_r  <= cand_have;
        best_pos_r   <= cand_pos;
        best_score_r <= cand_score;
      end
    end
  end

  gles_res_fifo #(
    .WIDTH (RES_W),
    .DEPTH (gles_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .pop       (out_tready),
    .pop_data  (head_bits),
    .not_empty (out_tvalid),
    .count     (q_count)
  );

  assign head_res  = head_bits;
  assign out_tuser = head_res.found;
  assign out_tdata = {5'b0, head_res.score, head_res.pos};

endmodule

// ----- rtl/gles_checker.sv -----
module gles_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gles_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item shown right after reset");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // Not-found results carry zero position and score
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero payload");

  // With the result queue empty the input side is never throttled
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result queue");

  // A result cannot appear from nothing: the queue only grows after input traffic
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid, 4) || $past(in_tready, 4))
    else $error("result item without an earlier input cycle");

endmodule

bind gradient_line_edge_search gles_checker u_gles_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/tb.sv -----
module tb;

  localparam int unsigned SUM_TOP   = 2097151;
  localparam int unsigned HITS_TOP  = 8191;
  localparam longint      SCORE_TOP = 4194303;
  localparam longint      SCORE_BOT = -4194304;
  localparam int          N_DIR     = 15;
  localparam int          N_PHASES  = 7;

  typedef struct packed {
    logic                        kind;
    logic [gles_pkg::POS_W-1:0]  exp_pos;
    logic [gles_pkg::SPAN_W-1:0] span;
    logic [gles_pkg::GRAD_W-1:0] grad;
    logic [gles_pkg::POS_W-1:0]  pos;
    logic                        lend;
    logic                        jend;
  } gl_item_t;

  // nf: the job end on this row must report not-found
  typedef struct packed {
    gl_item_t it;
    int       reps;
    logic     nf;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [gles_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [gles_pkg::CFG_W-1:0]      cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gles_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  logic [gles_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  gradient_line_edge_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // edge search predictor state
  logic [gles_pkg::CFG_W-1:0] thr_reg = gles_pkg::HIT_THRESHOLD_RST;
  logic [gles_pkg::CFG_W-1:0] clamp_reg = gles_pkg::SAMPLE_CLAMP_RST;
  int unsigned                run_sum = 0;
  int unsigned                run_hits = 0;
  logic [gles_pkg::POS_W-1:0] lead_pos = '0;
  longint                     lead_score = 0;
  bit                         lead_valid = 1'b0;
  logic [gles_pkg::POS_W-1:0] job_center = '0;
  int unsigned                job_len = 0;

  gles_pkg::result_t pending_edges[$];
  int                fail_cnt = 0;
  int                sent_cnt = 0;
  int                burst_left = 0;
  int                rdy_cnt = 0;
  dir_row_t          dir_tab[N_DIR];

  function automatic void clear_search();
    run_sum    = 0;
    run_hits   = 0;
    lead_pos   = '0;
    lead_score = 0;
    lead_valid = 1'b0;
  endfunction

  function automatic void score_line(logic [gles_pkg::POS_W-1:0] pos);
    longint pos_delta;
    longint sc;
    pos_delta = longint'(pos) - longint'(job_center);
    if (pos_delta < 0) pos_delta = -pos_delta;
    if (job_len < gles_pkg::MIN_SPAN || pos_delta > longint'(gles_pkg::SEARCH_RADIUS)) return;
    if (longint'(run_hits) * 20 < 11 * longint'(job_len)) return;
    sc = 2 * longint'(run_sum) + 256 * longint'(run_hits)
       - 3 * longint'(job_len) * pos_delta;
    if (sc > SCORE_TOP) sc = SCORE_TOP;
    if (sc < SCORE_BOT) sc = SCORE_BOT;
    if (!lead_valid || sc > lead_score) begin
      lead_valid = 1'b1;
      lead_score = sc;
      lead_pos   = pos;
    end
  endfunction

  function automatic void predict_edge(gl_item_t it);
    int unsigned       v;
    gles_pkg::result_t r;
    if (it.kind == gles_pkg::KIND_HEADER) begin
      job_center = it.exp_pos;
      job_len    = (it.span > gles_pkg::LINE_MAX) ? gles_pkg::LINE_MAX : 32'(it.span);
      clear_search();
      return;
    end
    v = 32'((it.grad < clamp_reg) ? it.grad : clamp_reg);
    run_sum = (run_sum + v > SUM_TOP) ? SUM_TOP : run_sum + v;
    if (it.grad >= thr_reg && run_hits < HITS_TOP) run_hits++;
    if (it.lend || it.jend) begin
      score_line(it.pos);
      run_sum  = 0;
      run_hits = 0;
    end
    if (it.jend) begin
      r.found = lead_valid;
      r.pos   = lead_valid ? lead_pos : '0;
      r.score = lead_valid ? gles_pkg::SCORE_W'(lead_score) : '0;
      pending_edges.push_back(r);
      clear_search();
    end
  endfunction

  function automatic logic [gles_pkg::GRAD_W-1:0] pick_grad(bit hit);
    if (hit) return gles_pkg::GRAD_W'($urandom_range(1020, thr_reg));
    if (thr_reg == 0) return gles_pkg::GRAD_W'($urandom_range(1020, 0));
    return gles_pkg::GRAD_W'($urandom_range(thr_reg - 1, 0));
  endfunction

  function automatic logic [gles_pkg::SPAN_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 8)  return gles_pkg::SPAN_W'($urandom_range(39, 0));
    if (r < 78) return gles_pkg::SPAN_W'($urandom_range(64, 40));
    if (r < 90) return gles_pkg::SPAN_W'($urandom_range(300, 65));
    if (r < 95) return gles_pkg::SPAN_W'($urandom_range(8191, 4096));
    return gles_pkg::SPAN_W'($urandom_range(4095, 301));
  endfunction

  function automatic gl_item_t rand_item();
    gl_item_t it;
    it.kind    = 1'($urandom_range(1, 0));
    it.exp_pos = gles_pkg::POS_W'($urandom);
    it.span    = gles_pkg::SPAN_W'($urandom);
    it.grad    = gles_pkg::GRAD_W'($urandom_range(1020, 0));
    it.pos     = gles_pkg::POS_W'($urandom);
    it.lend    = 1'($urandom_range(1, 0));
    it.jend    = ($urandom_range(7, 0) == 0);
    return it;
  endfunction

  // sender: bursts of items, mostly separated by random idle gaps
  task automatic send_item(gl_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.lend, it.pos, it.grad, it.span, it.exp_pos};
    in_tuser  <= it.kind;
    in_tlast  <= it.jend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_edge(it);
    burst_left--;
    sent_cnt++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(logic [gles_pkg::CFG_W-1:0] thr,
                            logic [gles_pkg::CFG_W-1:0] clamp);
    cfg_we    <= 1'b1;
    cfg_idx   <= gles_pkg::REG_HIT_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= gles_pkg::REG_SAMPLE_CLAMP;
    cfg_wdata <= clamp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_reg   = thr;
    clamp_reg = clamp;
  endtask

  task automatic send_line(logic [gles_pkg::POS_W-1:0] pos, int unsigned g_lo,
                           int unsigned g_hi, int n, logic jend);
    gl_item_t it;
    for (int s = 0; s < n; s++) begin
      it      = rand_item();
      it.kind = gles_pkg::KIND_SAMPLE;
      it.grad = gles_pkg::GRAD_W'($urandom_range(g_hi, g_lo));
      it.pos  = pos;
      it.lend = (s == n - 1);
      it.jend = (s == n - 1) && jend;
      send_item(it);
    end
  endtask

  // one search job: mostly well formed, with a missing header or stray items now and then
  task automatic run_job();
    gl_item_t                   it;
    int                         lines;
    int                         nsamp;
    int                         lo;
    int                         hit_pct;
    logic [gles_pkg::POS_W-1:0] pos;
    if ($urandom_range(9, 0) != 0) begin
      it      = rand_item();
      it.kind = gles_pkg::KIND_HEADER;
      it.span = pick_span();
      send_item(it);
    end
    lines = $urandom_range(4, 1);
    for (int l = 0; l < lines; l++) begin
      if (job_len >= gles_pkg::MIN_SPAN && job_len <= 300) begin
        lo    = job_len * 11 / 20;
        nsamp = $urandom_range(job_len + 4, (lo > 4) ? lo - 4 : 1);
      end else begin
        nsamp = $urandom_range(60, 1);
      end
      hit_pct = $urandom_range(100, 30);
      pos     = gles_pkg::POS_W'(int'(job_center) + int'($urandom_range(140, 0)) - 70);
      for (int s = 0; s < nsamp; s++) begin
        if ($urandom_range(39, 0) == 0) send_item(rand_item());
        it      = rand_item();
        it.kind = gles_pkg::KIND_SAMPLE;
        it.grad = pick_grad($urandom_range(100, 1) <= hit_pct);
        it.pos  = pos;
        it.jend = (s == nsamp - 1) && (l == lines - 1);
        it.lend = (s == nsamp - 1) && (l != lines - 1 || $urandom_range(1, 0));
        send_item(it);
      end
    end
  endtask

  // receiver: alternating ready and stall stretches of random length
  always @(posedge clk) begin
    if (rdy_cnt != 0) begin
      rdy_cnt <= rdy_cnt - 1;
    end else begin
      out_tready <= ~out_tready;
      rdy_cnt    <= out_tready ? $urandom_range(24, 0) : $urandom_range(60, 0);
    end
  end

  always @(posedge clk) begin
    gles_pkg::result_t seen;
    gles_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.found = out_tuser;
      seen.pos   = out_tdata[gles_pkg::POS_W-1:0];
      seen.score = out_tdata[gles_pkg::POS_W +: gles_pkg::SCORE_W];
      if (pending_edges.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected edge item: found=%0b pos=%0d score=%0d",
                   seen.found, seen.pos, seen.score);
      end else begin
        want = pending_edges.pop_front();
        if (seen.found !== want.found || seen.pos !== want.pos ||
            seen.score !== want.score) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("edge mismatch: exp found=%0b pos=%0d score=%0d, got found=%0b pos=%0d score=%0d",
                     want.found, want.pos, want.score, seen.found, seen.pos, seen.score);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    gl_item_t                   it;
    int                         quota;
    logic [gles_pkg::CFG_W-1:0] thr;
    logic [gles_pkg::CFG_W-1:0] clamp;
    int                         thr_set[N_PHASES];
    int                         clamp_set[N_PHASES];

    // {kind, exp_pos, span, grad, pos, line_last, job_last}, repeat count, not-found
    dir_tab = '{
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd0, 12'd0, 1'b0, 1'b1}, 1, 1'b1},     // job end before any header
      '{'{gles_pkg::KIND_HEADER, 12'd4095, 13'd8191, 10'd0, 12'd0, 1'b0, 1'b0}, 1, 1'b0}, // span above LINE_MAX
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd1020, 12'd4095, 1'b0, 1'b1}, 1, 1'b1},
      '{'{gles_pkg::KIND_HEADER, 12'd0, 13'd39, 10'd0, 12'd0, 1'b0, 1'b0}, 1, 1'b0},
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd1020, 12'd0, 1'b1, 1'b1}, 30, 1'b1},  // span too short
      '{'{gles_pkg::KIND_HEADER, 12'd2000, 13'd40, 10'd0, 12'd0, 1'b0, 1'b0}, 1, 1'b0},
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd1020, 12'd1999, 1'b1, 1'b0}, 22, 1'b0},
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd63, 12'd2001, 1'b1, 1'b0}, 3, 1'b0},   // under threshold
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd64, 12'd2065, 1'b1, 1'b0}, 22, 1'b0},  // one past radius
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd64, 12'd1936, 1'b1, 1'b0}, 22, 1'b0},  // on the radius
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd1020, 12'd2001, 1'b0, 1'b1}, 22, 1'b0}, // tie, earlier wins
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd10, 12'd5, 1'b0, 1'b1}, 3, 1'b1},      // job kept after end
      '{'{gles_pkg::KIND_HEADER, 12'd4095, 13'd4096, 10'h3ff, 12'd4095, 1'b1, 1'b1}, 1, 1'b0},
      '{'{gles_pkg::KIND_SAMPLE, 12'd4095, 13'd8191, 10'd0, 12'd4095, 1'b1, 1'b0}, 1, 1'b0},
      '{'{gles_pkg::KIND_SAMPLE, 12'd0, 13'd0, 10'd0, 12'd4095, 1'b0, 1'b1}, 1, 1'b1}
    };
    thr_set   = '{64, 0, 1020, 0, 1020, 0, 0};
    clamp_set = '{320, 0, 1020, 1020, 0, 0, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        it = dir_tab[r].it;
        if (k != dir_tab[r].reps - 1) begin
          it.lend = 1'b0;
          it.jend = 1'b0;
        end
        send_item(it);
      end
      if (dir_tab[r].nf) pending_edges[pending_edges.size() - 1] = '{1'b0, '0, '0};
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      thr   = (p < 5) ? gles_pkg::CFG_W'(thr_set[p])
                      : gles_pkg::CFG_W'($urandom_range(1020, 0));
      clamp = (p < 5) ? gles_pkg::CFG_W'(clamp_set[p])
                      : gles_pkg::CFG_W'($urandom_range(1020, 0));
      // the first phase runs on the reset values
      if (p != 0) set_limits(thr, clamp);
      quota = sent_cnt + 200;
      while (sent_cnt < quota) run_job();
      drain();
    end

    // a line on the search radius whose winning score is negative
    set_limits(10'd0, 10'd1020);
    it         = rand_item();
    it.kind    = gles_pkg::KIND_HEADER;
    it.exp_pos = 12'd100;
    it.span    = 13'd40;
    send_item(it);
    send_line(12'd36, 0, 0, 22, 1'b1);
    drain();

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
